// ----- rtl/core/pidhc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidhc_pkg
// Widths, limits, microcode field codes and register indexes shared by the
// heater/cooler PID controller and its sequencer.
// ----------------------------------------------------------------------------
package pidhc_pkg;

  // integrator width, legal range 24..48
  localparam int IntegWidth = 32;

  localparam int DataW  = 16;   // Q8.8 temperature / drive
  localparam int GainW  = 16;
  localparam int RateW  = 9;
  localparam int ErrW   = DataW + 1;
  localparam int DerrW  = DataW + 2;
  localparam int OpAW   = 18;
  localparam int OpBW   = IntegWidth;
  localparam int ProdW  = OpAW + OpBW;
  localparam int AccW   = 43;   // p + clipped i + d terms in Q16.16
  localparam int MagW   = DataW - 1;
  localparam int PcW    = 4;
  localparam int CfgIdxW = 3;

  localparam int DriveLim     = 25600;          // 100.0 in Q8.8
  localparam int DriveLimWide = DriveLim * 256; // same in Q16.16
  localparam longint ItermLim = 64'sd1 <<< 40;
  localparam int RoundHalf    = 128;
  localparam int FracBits     = 8;

  // power = floor((mag*rate + lim/2) / lim), lim = 256*100:
  // shift by 8, then multiply by ceil(2^23/100) and shift by 23
  localparam int PowRound   = DriveLim / 2;
  localparam int QuotW      = 16;
  localparam int Recip      = 83887;
  localparam int RecipShift = 23;

  typedef enum logic [2:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_GAIN_P    = 3'd1,
    CFG_GAIN_I    = 3'd2,
    CFG_GAIN_D    = 3'd3,
    CFG_HEAT_RATE = 3'd4,
    CFG_COOL_RATE = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    A_GAIN_P, A_GAIN_I, A_GAIN_D, A_HEAT, A_COOL, A_RECIP
  } asel_t;

  typedef enum logic [2:0] {
    B_ERR, B_SUM, B_DERR, B_MAG, B_QUOT
  } bsel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD_CLIP, ACC_ADD, ACC_RND
  } acc_op_t;

  typedef enum logic [1:0] {
    J_NEXT, J_NEG, J_ALWAYS, J_END
  } jmp_t;

  typedef struct packed {
    asel_t   a_sel;
    bsel_t   b_sel;
    logic    mul_en;
    acc_op_t acc_op;
    logic    drive_en;
    logic    out_en;
  } ctrl_t;

  typedef struct packed {
    ctrl_t          ctrl;
    jmp_t           jmp;
    logic [PcW-1:0] target;
  } ucode_t;

endpackage

// ----- rtl/core/pidhc_seq.sv -----
// ----------------------------------------------------------------------------
// pidhc_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module pidhc_seq import pidhc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  neg,
  input  logic  out_full,
  output logic  busy,
  output ctrl_t ctrl
);

  localparam logic [PcW-1:0] PcCool = PcW'(7);
  localparam logic [PcW-1:0] PcRnd  = PcW'(8);

  logic [PcW-1:0] pc;
  ucode_t         word;
  logic           hold;
  logic           exec;

  function automatic ucode_t uw(input asel_t a, input bsel_t b, input logic m,
                                input acc_op_t ac, input logic dv, input logic o,
                                input jmp_t j, input logic [PcW-1:0] t);
    ucode_t w;
    w.ctrl.a_sel    = a;
    w.ctrl.b_sel    = b;
    w.ctrl.mul_en   = m;
    w.ctrl.acc_op   = ac;
    w.ctrl.drive_en = dv;
    w.ctrl.out_en   = o;
    w.jmp           = j;
    w.target        = t;
    return w;
  endfunction

  function automatic ucode_t rom(input logic [PcW-1:0] a);
    ucode_t w;
    unique case (a)
      PcW'(0):  w = uw(A_GAIN_P, B_ERR,  1'b1, ACC_HOLD,     1'b0, 1'b0, J_NEXT,   '0);
      PcW'(1):  w = uw(A_GAIN_I, B_SUM,  1'b1, ACC_LOAD,     1'b0, 1'b0, J_NEXT,   '0);
      PcW'(2):  w = uw(A_GAIN_D, B_DERR, 1'b1, ACC_ADD_CLIP, 1'b0, 1'b0, J_NEXT,   '0);
      PcW'(3):  w = uw(A_GAIN_P, B_ERR,  1'b0, ACC_ADD,      1'b0, 1'b0, J_NEXT,   '0);
      PcW'(4):  w = uw(A_GAIN_P, B_ERR,  1'b0, ACC_HOLD,     1'b1, 1'b0, J_NEXT,   '0);
      PcW'(5):  w = uw(A_GAIN_P, B_ERR,  1'b0, ACC_HOLD,     1'b0, 1'b0, J_NEG,    PcCool);
      PcW'(6):  w = uw(A_HEAT,   B_MAG,  1'b1, ACC_HOLD,     1'b0, 1'b0, J_ALWAYS, PcRnd);
      PcW'(7):  w = uw(A_COOL,   B_MAG,  1'b1, ACC_HOLD,     1'b0, 1'b0, J_NEXT,   '0);
      PcW'(8):  w = uw(A_GAIN_P, B_ERR,  1'b0, ACC_RND,      1'b0, 1'b0, J_NEXT,   '0);
      PcW'(9):  w = uw(A_RECIP,  B_QUOT, 1'b1, ACC_HOLD,     1'b0, 1'b0, J_NEXT,   '0);
      PcW'(10): w = uw(A_GAIN_P, B_ERR,  1'b0, ACC_HOLD,     1'b0, 1'b1, J_END,    '0);
      default:  w = uw(A_GAIN_P, B_ERR,  1'b0, ACC_HOLD,     1'b0, 1'b0, J_END,    '0);
    endcase
    return w;
  endfunction

  assign word = rom(pc);
  // result step waits while the output register still holds an untaken beat
  assign hold = word.ctrl.out_en & out_full;
  assign exec = busy & ~hold;
  assign ctrl = exec ? word.ctrl : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (exec) begin
      unique case (word.jmp)
        J_NEXT:   pc <= pc + PcW'(1);
        J_NEG:    pc <= neg ? word.target : pc + PcW'(1);
        J_ALWAYS: pc <= word.target;
        J_END:    busy <= 1'b0;
        default:  busy <= 1'b0;
      endcase
    end
  end

endmodule

// ----- rtl/core/pid_heater_cooler_controller.sv -----
// ----------------------------------------------------------------------------
// pid_heater_cooler_controller
// PID temperature controller with saturating integrator, clamped drive and
// split heater / cooler power outputs.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   measured_temp
//   out      source     out_valid / out_ready drive, heat_power,
//                                             cooling_power, clamped
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// For each sample, the accept cycle forms error, integral and
// error difference, then 10 microcode steps share one 18 x IntegWidth
// multiplier, at most one product per step. A new sample is taken once the
// result has moved into the output register. A stalled output holds the
// sequencer on its last step. Synchronous reset restores register defaults
// and clears integral and previous error. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_heater_cooler_controller import pidhc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DataW-1:0] measured_temp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] drive,
  output logic [RateW-1:0]        heat_power,
  output logic [RateW-1:0]        cooling_power,
  output logic                    clamped,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [DataW-1:0]        cfg_data
);

  logic signed [DataW-1:0] setpoint;
  logic [GainW-1:0]        gain_p;
  logic [GainW-1:0]        gain_i;
  logic [GainW-1:0]        gain_d;
  logic [RateW-1:0]        heat_rate;
  logic [RateW-1:0]        cool_rate;

  logic signed [ErrW-1:0]       last_error;
  logic signed [IntegWidth-1:0] integral;
  logic signed [DerrW-1:0]      derr;
  logic signed [ProdW-1:0]      prod;
  logic signed [AccW-1:0]       acc;
  logic signed [DataW-1:0]      drive_r;
  logic                         clamp_r;
  logic [MagW-1:0]              mag;

  logic                         busy;
  ctrl_t                        ctrl;
  logic                         in_fire;
  logic                         out_full;

  logic signed [ErrW-1:0]       err_in;
  logic signed [IntegWidth:0]   sum_wide;
  logic signed [IntegWidth-1:0] sum_sat;
  logic signed [DerrW-1:0]      derr_in;
  logic signed [OpAW-1:0]       opa;
  logic signed [OpBW-1:0]       opb;
  logic signed [ProdW-1:0]      iclip;
  logic signed [AccW-1:0]       rnd;
  logic signed [DataW-1:0]      drive_next;
  logic                         clamp_next;
  logic [MagW-1:0]              mag_next;
  logic [RateW-1:0]             power;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~busy;
  assign in_fire   = in_valid & in_ready;
  assign out_full  = out_valid & ~out_ready;

  pidhc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .neg      (drive_r[DataW-1]),
    .out_full (out_full),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= DataW'(5632);
      gain_p    <= GainW'(5120);
      gain_i    <= GainW'(128);
      gain_d    <= GainW'(512);
      heat_rate <= RateW'(171);
      cool_rate <= RateW'(171);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SETPOINT:  setpoint  <= cfg_data;
        CFG_GAIN_P:    gain_p    <= cfg_data;
        CFG_GAIN_I:    gain_i    <= cfg_data;
        CFG_GAIN_D:    gain_d    <= cfg_data;
        CFG_HEAT_RATE: heat_rate <= cfg_data[RateW-1:0];
        CFG_COOL_RATE: cool_rate <= cfg_data[RateW-1:0];
        default: ;
      endcase
    end
  end

  // front end, evaluated on the accepted beat
  always_comb begin
    err_in   = ErrW'(setpoint) - ErrW'(measured_temp);
    sum_wide = (IntegWidth+1)'(integral) + (IntegWidth+1)'(err_in);
    if (sum_wide[IntegWidth] != sum_wide[IntegWidth-1]) begin
      sum_sat = sum_wide[IntegWidth] ? {1'b1, {(IntegWidth-1){1'b0}}}
                                     : {1'b0, {(IntegWidth-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[IntegWidth-1:0];
    end
    derr_in = DerrW'(err_in) - DerrW'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral   <= '0;
    end else if (in_fire) begin
      last_error <= err_in;
      integral   <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      derr <= derr_in;
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (ctrl.a_sel)
      A_GAIN_P: opa = OpAW'(gain_p);
      A_GAIN_I: opa = OpAW'(gain_i);
      A_GAIN_D: opa = OpAW'(gain_d);
      A_HEAT:   opa = OpAW'(heat_rate);
      A_COOL:   opa = OpAW'(cool_rate);
      A_RECIP:  opa = OpAW'(Recip);
      default:  opa = '0;
    endcase
    unique case (ctrl.b_sel)
      B_ERR:   opb = OpBW'(last_error);   // error of the current sample
      B_SUM:   opb = integral;
      B_DERR:  opb = OpBW'(derr);
      B_MAG:   opb = OpBW'(mag);
      B_QUOT:  opb = OpBW'(acc[FracBits+QuotW-1:FracBits]);
      default: opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= opa * opb;
    end
  end

  // integral term limited to +-2^40 in Q16.16
  always_comb begin
    if (prod > ProdW'(ItermLim)) begin
      iclip = ProdW'(ItermLim);
    end else if (prod < ProdW'(-ItermLim)) begin
      iclip = ProdW'(-ItermLim);
    end else begin
      iclip = prod;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.acc_op)
      ACC_HOLD:     acc <= acc;
      ACC_LOAD:     acc <= AccW'(prod);
      ACC_ADD_CLIP: acc <= acc + AccW'(iclip);
      ACC_ADD:      acc <= acc + AccW'(prod);
      ACC_RND:      acc <= AccW'(prod) + AccW'(PowRound);
      default:      acc <= acc;
    endcase
  end

  // clamp to +-100.0, else round half up to Q8.8
  always_comb begin
    rnd = acc + AccW'(RoundHalf);
    priority if (acc > AccW'(DriveLimWide)) begin
      drive_next = DataW'(DriveLim);
      clamp_next = 1'b1;
    end else if (acc < AccW'(-DriveLimWide)) begin
      drive_next = DataW'(-DriveLim);
      clamp_next = 1'b1;
    end else begin
      drive_next = rnd[FracBits+DataW-1:FracBits];
      clamp_next = 1'b0;
    end
    mag_next = drive_next[DataW-1] ? MagW'(-drive_next) : MagW'(drive_next);
  end

  always_ff @(posedge clk) begin
    if (ctrl.drive_en) begin
      drive_r <= drive_next;
      clamp_r <= clamp_next;
      mag     <= mag_next;
    end
  end

  assign power = prod[RecipShift+RateW-1:RecipShift];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      drive         <= drive_r;
      clamped       <= clamp_r;
      heat_power    <= drive_r[DataW-1] ? '0 : power;
      cooling_power <= drive_r[DataW-1] ? power : '0;
    end
  end

endmodule
